@@ rtl/apbs_pkg.sv @@
// Package for the access-pattern bank switch: payload structs, page and
// pattern constants, and the bank choice function.
// No dependencies.
package apbs_pkg;

  localparam int OFFSET_W = 14;
  localparam int ADDR_W   = 17;
  localparam int PAGE_W   = 6;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 3;

  // Page codes are offset[13:8]
  localparam logic [PAGE_W-1:0]   PAGE_ARM    = 6'h20;
  localparam logic [PAGE_W-1:0]   PAGE_COUNT  = 6'h35;
  localparam logic [OFFSET_W-1:0] ARM_OFFSET  = 14'h2000;

  localparam logic [BYTE_W-1:0]   LO_SEL_80   = 8'h80;
  localparam logic [BYTE_W-1:0]   LO_SEL_90   = 8'h90;
  localparam logic [BYTE_W-1:0]   LO_SEL_A0   = 8'ha0;
  localparam logic [BYTE_W-1:0]   LO_SEL_B0   = 8'hb0;
  localparam logic [BYTE_W-1:0]   LO_KEY_53   = 8'h53;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 3'd7;
  localparam logic [COUNT_W-1:0]  COUNT_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0]  COUNT_SIX   = 3'd6;

  localparam logic BANK_FIRST  = 1'b0;
  localparam logic BANK_SECOND = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] read_offset;
  } apbs_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rom_address;
    logic              bank_select;
  } apbs_out_t;

  // Bank chosen by a selecting read in the 0x20xx page
  function automatic logic choose_bank(
    input logic [BYTE_W-1:0]  lo,
    input logic [COUNT_W-1:0] count,
    input logic [BYTE_W-1:0]  last20,
    input logic [BYTE_W-1:0]  last35
  );
    logic bank;
    bank = BANK_SECOND;
    case (lo)
      LO_SEL_80: begin
        bank = BANK_SECOND;
      end
      LO_SEL_90: begin
        if (count == '0 || (count == COUNT_TWO && last20 == LO_SEL_90)) begin
          bank = BANK_FIRST;
        end
      end
      LO_SEL_A0: begin
        if (last20 == LO_SEL_B0) begin
          bank = BANK_FIRST;
        end
      end
      default: begin
        if (count == COUNT_SIX && last20 == LO_SEL_B0 && last35 == LO_KEY_53) begin
          bank = BANK_FIRST;
        end
      end
    endcase
    return bank;
  endfunction

endpackage

@@ rtl/apbs_if.sv @@
// Valid/ready channel interfaces for the bank switch input and result.
// Depends on apbs_pkg.
interface apbs_in_if
  import apbs_pkg::*;
();
  logic     valid;
  logic     ready;
  apbs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apbs_out_if
  import apbs_pkg::*;
();
  logic      valid;
  logic      ready;
  apbs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/access_pattern_bank_switch.sv @@
// Access-pattern bank switch: watches read offsets into a banked ROM window
// and returns the ROM address. Depends on apbs_pkg and apbs_if.
//
// Usage:
//   in_chan carries one read offset (14 bits) per transaction. out_chan
//   returns one transaction per read: rom_address (bank base plus offset,
//   wrapped to 17 bits) and bank_select (bank used for that read).
//   Reads drive a small pattern tracker: a read at 0x2000 arms it, 0x35xx
//   reads are counted (saturating at 7), and selecting reads in 0x20xx pick
//   the bank that takes effect from the following read on.
// Pipeline and throughput:
//   A read passes the input register, then the tracker update and address
//   add into the result register. One transaction per cycle sustained while
//   out_chan.ready stays high; the tracker update is a single level of
//   compares and a 17-bit add.
// Reset (rst_n low, synchronous):
//   Both stages empty, first bank active, nothing pending, disarmed,
//   history cleared.
// Stall:
//   When out_chan.ready is low the result register holds; the input
//   register fills one more transaction, then in_chan.ready drops until
//   the result is taken.
module access_pattern_bank_switch
  import apbs_pkg::*;
#(
  parameter int FIRST_BANK_BASE  = 16384,
  parameter int SECOND_BANK_BASE = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  apbs_in_if.sink           in_chan,
  apbs_out_if.source        out_chan
);

  // Bases wrap to the ROM address width, as the address itself does
  localparam logic [ADDR_W-1:0] FIRST_BASE  = ADDR_W'(FIRST_BANK_BASE);
  localparam logic [ADDR_W-1:0] SECOND_BASE = ADDR_W'(SECOND_BANK_BASE);

  // Pipeline control
  logic                v1_r, v2_r;
  logic                s2_load;
  logic [OFFSET_W-1:0] offset1_r;
  apbs_out_t           result_r, result_nxt;

  // Tracker state
  logic                active_bank_r,   active_bank_nxt;
  logic                pending_valid_r, pending_valid_nxt;
  logic                pending_bank_r,  pending_bank_nxt;
  logic                armed_r,         armed_nxt;
  logic [COUNT_W-1:0]  count_r,         count_nxt;
  logic [BYTE_W-1:0]   last20_r,        last20_nxt;
  logic [BYTE_W-1:0]   last35_r,        last35_nxt;

  logic [PAGE_W-1:0]   page;
  logic [BYTE_W-1:0]   lo;
  logic                bank_now;
  logic                sel_byte;

  // Advance stage 2 when it is empty or its result is being taken
  assign s2_load       = v1_r && (!v2_r || out_chan.ready);
  assign in_chan.ready = !v1_r || !v2_r || out_chan.ready;

  assign out_chan.valid = v2_r;
  assign out_chan.data  = result_r;

  assign page = offset1_r[OFFSET_W-1:BYTE_W];
  assign lo   = offset1_r[BYTE_W-1:0];

  always_comb begin
    // Apply a pending choice before this read
    bank_now          = pending_valid_r ? pending_bank_r : active_bank_r;
    active_bank_nxt   = bank_now;
    pending_valid_nxt = 1'b0;
    pending_bank_nxt  = pending_bank_r;
    armed_nxt         = armed_r;
    count_nxt         = count_r;
    last20_nxt        = last20_r;
    last35_nxt        = last35_r;
    sel_byte          = (lo == LO_SEL_80) || (lo == LO_SEL_90) ||
                        (lo == LO_SEL_A0) || (lo == LO_SEL_B0);

    if (offset1_r == ARM_OFFSET) begin
      // Arm and clear history, keep the last 0x35xx byte
      count_nxt  = '0;
      last20_nxt = '0;
      armed_nxt  = 1'b1;
    end else if (page == PAGE_COUNT) begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
      last35_nxt = lo;
    end else if (page == PAGE_ARM) begin
      if (armed_r) begin
        if (sel_byte) begin
          pending_bank_nxt  = choose_bank(lo, count_r, last20_r, last35_r);
          pending_valid_nxt = 1'b1;
        end else begin
          armed_nxt = 1'b0;
        end
      end
      last20_nxt = lo;
      count_nxt  = '0;
    end else begin
      armed_nxt = 1'b0;
    end

    result_nxt.bank_select = bank_now;
    result_nxt.rom_address = (bank_now ? SECOND_BASE : FIRST_BASE) +
                             ADDR_W'(offset1_r);
  end

  // Stage valids and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      active_bank_r   <= BANK_FIRST;
      pending_valid_r <= 1'b0;
      pending_bank_r  <= BANK_FIRST;
      armed_r         <= 1'b0;
      count_r         <= '0;
      last20_r        <= '0;
      last35_r        <= '0;
    end else begin
      if (in_chan.ready) begin
        v1_r <= in_chan.valid;
      end
      if (!v2_r || out_chan.ready) begin
        v2_r <= v1_r;
      end
      // Update the tracker once per read, as it moves into the result stage
      if (s2_load) begin
        active_bank_r   <= active_bank_nxt;
        pending_valid_r <= pending_valid_nxt;
        pending_bank_r  <= pending_bank_nxt;
        armed_r         <= armed_nxt;
        count_r         <= count_nxt;
        last20_r        <= last20_nxt;
        last35_r        <= last35_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      offset1_r <= in_chan.data.read_offset;
    end
    if (s2_load) begin
      result_r <= result_nxt;
    end
  end

endmodule

@@ rtl/apbs_checker.sv @@
// Port-level checks for the access-pattern bank switch, bound to its top.
// Depends on access_pattern_bank_switch and apbs_pkg.
module apbs_checker
  import apbs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_rom_address,
  input logic              out_bank_select
);

  // Results are gone after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted read is followed by a valid result once it has passed the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after acceptance");

  // Input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // A blocked result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rom_address) &&
      $stable(out_bank_select))
    else $error("blocked result changed");

endmodule

bind access_pattern_bank_switch apbs_checker u_apbs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_rom_address (out_chan.data.rom_address),
  .out_bank_select (out_chan.data.bank_select)
);

@@ sim/apbs_sb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the access-pattern bank switch: tracks the read pattern,
// predicts rom_address and bank_select per read, and checks results in order.
// Depends on apbs_pkg.
package apbs_sb_pkg;
  import apbs_pkg::*;

  class rom_addr_scoreboard;
    int unsigned        first_base;
    int unsigned        second_base;
    apbs_out_t          expected_q[$];
    int unsigned        mismatches;

    // Tracker state, as seen from outside the block
    logic               cur_bank;
    logic               next_bank;
    logic               next_valid;
    logic               armed;
    logic [COUNT_W-1:0] count35;
    logic [BYTE_W-1:0]  last20;
    logic [BYTE_W-1:0]  last35;

    function new(int unsigned first, int unsigned second);
      first_base  = first;
      second_base = second;
      mismatches  = 0;
      cur_bank    = BANK_FIRST;
      next_bank   = BANK_FIRST;
      next_valid  = 1'b0;
      armed       = 1'b0;
      count35     = '0;
      last20      = '0;
      last35      = '0;
    endfunction

    // Apply one accepted read and queue the result it must produce
    function void note_read(apbs_in_t rd);
      logic [PAGE_W-1:0] page;
      logic [BYTE_W-1:0] lo;
      logic [31:0]       sum;
      apbs_out_t         exp_res;
      page = rd.read_offset[OFFSET_W-1:BYTE_W];
      lo   = rd.read_offset[BYTE_W-1:0];

      // a bank picked by the previous read takes over now
      if (next_valid) begin
        cur_bank   = next_bank;
        next_valid = 1'b0;
      end

      if (rd.read_offset == ARM_OFFSET) begin
        count35 = '0;
        last20  = '0;
        armed   = 1'b1;
      end else if (page == PAGE_COUNT) begin
        if (count35 != COUNT_MAX) begin
          count35 = count35 + COUNT_W'(1);
        end
        last35 = lo;
      end else if (page == PAGE_ARM) begin
        if (armed) begin
          next_valid = 1'b1;
          case (lo)
            LO_SEL_80: next_bank = BANK_SECOND;
            LO_SEL_90: begin
              next_bank = (count35 == '0 || (count35 == COUNT_TWO && last20 == LO_SEL_90))
                          ? BANK_FIRST : BANK_SECOND;
            end
            LO_SEL_A0: next_bank = (last20 == LO_SEL_B0) ? BANK_FIRST : BANK_SECOND;
            LO_SEL_B0: begin
              next_bank = (count35 == COUNT_SIX && last20 == LO_SEL_B0 && last35 == LO_KEY_53)
                          ? BANK_FIRST : BANK_SECOND;
            end
            default: begin
              next_valid = 1'b0;
              armed      = 1'b0;
            end
          endcase
        end
        last20  = lo;
        count35 = '0;
      end else begin
        armed = 1'b0;
      end

      sum = (cur_bank == BANK_SECOND ? second_base : first_base) + 32'(rd.read_offset);
      exp_res.rom_address = sum[ADDR_W-1:0];
      exp_res.bank_select = cur_bank;
      expected_q.push_back(exp_res);
    endfunction

    function void report(string msg);
      if (mismatches < 10) begin
        $display("MISMATCH: %s", msg);
      end
      mismatches++;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(apbs_out_t got);
      apbs_out_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result rom_address=%05h bank_select=%0d",
                         got.rom_address, got.bank_select));
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.rom_address !== exp_res.rom_address) begin
        report($sformatf("rom_address expected %05h actual %05h",
                         exp_res.rom_address, got.rom_address));
      end
      if (got.bank_select !== exp_res.bank_select) begin
        report($sformatf("bank_select expected %0d actual %0d (rom_address %05h)",
                         exp_res.bank_select, got.bank_select, exp_res.rom_address));
      end
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level bench for access_pattern_bank_switch: drives read offsets with
// bursty valid, stalls the result side, checks every result in order.
// Depends on apbs_pkg, apbs_if, apbs_sb_pkg and the block RTL.
module tb_top;
  import apbs_pkg::*;
  import apbs_sb_pkg::*;

  localparam int unsigned FIRST_BASE       = 16384;
  localparam int unsigned SECOND_BASE      = 65536;
  localparam int          READ_TOTAL       = 1100;
  localparam int          LONG_HOLD_AT     = 400;   // reads sent before the long stall
  localparam int          LONG_HOLD_CYCLES = 150;
  localparam int          DRAIN_CYCLES     = 8;     // margin after the last expected result
  localparam int          WATCHDOG_LIMIT   = 2000;

  logic clk;
  logic rst_n;

  apbs_in_if  in_chan ();
  apbs_out_if out_chan ();

  access_pattern_bank_switch #(
    .FIRST_BANK_BASE  (FIRST_BASE),
    .SECOND_BANK_BASE (SECOND_BASE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rom_addr_scoreboard sb = new(FIRST_BASE, SECOND_BASE);

  int unsigned reads_sent    = 0;
  int unsigned burst_left    = 0;
  bit          long_hold_done = 1'b0;
  int unsigned idle_cycles   = 0;

  // 2 ns clock, low phase first so time zero carries no edge
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Monitor: sample both channels on the edge, before any update lands.
  // Note the read first; its result cannot show up in the same cycle anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_read(in_chan.data);
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.data);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one read and hold it until accepted. Between bursts, drop valid
  // for a random gap; some bursts run long with no gap at all.
  task automatic send_read(input logic [OFFSET_W-1:0] off);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid            <= 1'b1;
    in_chan.data.read_offset <= off;
    do @(posedge clk); while (!in_chan.ready);
    reads_sent++;
  endtask

  // One arming sequence: arm at 0x2000, then a few steps of 0x35xx counting
  // reads followed by a 0x20xx read, or one time in ten a random read. Counts of
  // 2 and 6 and the 0x53 key byte are favored so the first-bank choices get hit often.
  task automatic send_pattern();
    int unsigned       steps;
    int unsigned       n35;
    int unsigned       pick;
    logic [BYTE_W-1:0] sel;
    send_read(ARM_OFFSET);
    steps = $urandom_range(1, 4);
    repeat (steps) begin
      case ($urandom_range(0, 3))
        0:       n35 = 0;
        1:       n35 = 2;
        2:       n35 = 6;
        default: n35 = $urandom_range(0, 9);
      endcase
      repeat (n35) begin
        send_read({PAGE_COUNT, ($urandom_range(0, 1) != 0) ? LO_KEY_53 : BYTE_W'($urandom)});
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    sel = LO_SEL_80;
        2, 3:    sel = LO_SEL_90;
        4, 5:    sel = LO_SEL_A0;
        6, 7:    sel = LO_SEL_B0;
        default: sel = BYTE_W'($urandom);
      endcase
      if (pick == 9) begin
        send_read(OFFSET_W'($urandom));  // break the sequence anywhere
      end else begin
        send_read({PAGE_ARM, sel});
      end
    end
  endtask

  // Receiver: ready follows a random mode that changes from chunk to chunk;
  // once, after enough reads, hold off long enough to back up the input.
  initial begin
    int unsigned mode;
    int unsigned chunk;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode  = $urandom_range(0, 3);
      chunk = $urandom_range(16, 96);
      for (int k = 0; k < chunk; k++) begin
        if (!long_hold_done && reads_sent >= LONG_HOLD_AT) begin
          long_hold_done = 1'b1;
          out_chan.ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= ($urandom_range(0, 1) != 0);
          2:       out_chan.ready <= (k % 3 != 0);
          default: out_chan.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Directed reads: window extremes, each selecting byte, the first-bank
  // choices for 0x90, 0xA0 and 0xB0, counter saturation, and disarming.
  logic [OFFSET_W-1:0] directed_reads[] = '{
    14'h0000, 14'h3fff,                       // extremes, disarmed
    14'h2000, 14'h2080,                       // arm, 0x80 -> second bank
    14'h2000, 14'h2090,                       // count 0 with 0x90 -> first bank
    14'h20b0, 14'h20a0,                       // 0xA0 after 0xB0 -> first bank
    14'h20b0,                                 // last 0x20 byte now 0xB0
    14'h3500, 14'h35ff, 14'h3512, 14'h3534,
    14'h3545, 14'h3553, 14'h20b0,             // six counts, key 0x53 -> first bank
    14'h2000,
    14'h3501, 14'h3502, 14'h3503, 14'h3504,
    14'h3505, 14'h3506, 14'h3507, 14'h3508,   // eight counts, must stick at 7
    14'h2090,                                 // saturated count -> second bank
    14'h2077, 14'h3fff                        // disarm, show the bank
  };

  initial begin
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reads[i]) begin
      send_read(directed_reads[i]);
    end

    // Mostly well-formed sequences, the rest random reads across the window
    while (reads_sent < READ_TOTAL) begin
      if ($urandom_range(0, 9) < 7) begin
        send_pattern();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0:       send_read({PAGE_ARM, BYTE_W'($urandom)});
            1:       send_read({PAGE_COUNT, BYTE_W'($urandom)});
            default: send_read(OFFSET_W'($urandom));
          endcase
        end
      end
    end
    in_chan.valid <= 1'b0;

    // Drain: wait for every outstanding result, then idle for DRAIN_CYCLES
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ access_pattern_bank_switch.f @@
rtl/apbs_pkg.sv
rtl/apbs_if.sv
rtl/access_pattern_bank_switch.sv
rtl/apbs_checker.sv
sim/apbs_sb_pkg.sv
sim/tb_top.sv
